// ===== rtl/core/balance_robot_motor_mixer_assert.svh =====
// ----------------------------------------------------------------------------
// Motor mixer assertion macros
// Concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef BALANCE_ROBOT_MOTOR_MIXER_ASSERT_SVH
`define BALANCE_ROBOT_MOTOR_MIXER_ASSERT_SVH

// same-cycle implication
`define BRMM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BRMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/brmm_pkg.sv =====
// ----------------------------------------------------------------------------
// brmm_pkg
// Shared widths, constants, codes and types of the motor mixer.
// ----------------------------------------------------------------------------
package brmm_pkg;

  localparam int IN_W    = 16;   // sensor, command and gain words
  localparam int OUT_W   = 11;   // drive words
  localparam int IDX_W   = 3;    // config register index
  localparam int FILT_W  = 24;   // filtered wheel speed, Q8
  localparam int INTEG_W = 28;   // speed integral, Q8
  localparam int FS_W    = 26;   // filter update sum
  localparam int SUM_W   = 28;   // balance/speed/turn terms

  // serial multiplier: wide operand a, digit-serial operand b
  localparam int MA_W  = 44;
  localparam int MB_W  = 20;
  localparam int DIG_W = 4;
  localparam int ND    = MB_W / DIG_W;
  localparam int CNT_W = $clog2(ND);
  localparam int P_W   = 64;

  localparam int OUT_LIMIT = 1000;

  localparam logic signed [SUM_W-1:0]   DRV_MAX   = SUM_W'(OUT_LIMIT);
  localparam logic signed [SUM_W-1:0]   DRV_MIN   = -DRV_MAX;
  localparam logic signed [OUT_W-1:0]   DRIVE_LIM = OUT_W'(OUT_LIMIT);
  localparam logic signed [FS_W-1:0]    FILT_MAX  = FS_W'((1 << (FILT_W - 1)) - 1);
  localparam logic signed [FS_W-1:0]    FILT_MIN  = FS_W'(-(1 << (FILT_W - 1)));
  localparam logic signed [INTEG_W-1:0] INTEG_MAX = INTEG_W'(20 * OUT_LIMIT * 256);
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = -INTEG_MAX;

  // Q8 filter weights 0.8 / 0.2 and Q16 0.1
  localparam logic signed [MB_W-1:0] COEF_OLD   = MB_W'(205);
  localparam logic signed [MB_W-1:0] COEF_NEW   = MB_W'(51);
  localparam logic signed [MB_W-1:0] COEF_TENTH = MB_W'(6554);

  localparam logic signed [IN_W-1:0] PITCH_SP_RST = IN_W'(384);

  typedef enum logic [IDX_W-1:0] {
    REG_ANGLE_KP = 3'd0,
    REG_ANGLE_KD = 3'd1,
    REG_SPEED_KP = 3'd2,
    REG_SPEED_KI = 3'd3,
    REG_TURN_KP  = 3'd4,
    REG_TURN_KD  = 3'd5,
    REG_PITCH_SP = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BAL_P,
    ST_BAL_D,
    ST_FILT_A,
    ST_FILT_B,
    ST_INTEG,
    ST_SPD_P,
    ST_SPD_I1,
    ST_SPD_I2,
    ST_TRN_P,
    ST_TRN_D,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                   start;
    logic signed [MA_W-1:0] a;
    logic signed [MB_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                  done;
    logic signed [P_W-1:0] p;
  } mul_rsp_t;

endpackage

// ===== rtl/core/brmm_in_if.sv =====
// ----------------------------------------------------------------------------
// brmm_in_if
// Sensor/command word channel, valid/ready.
// ----------------------------------------------------------------------------
interface brmm_in_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic signed [brmm_pkg::IN_W-1:0]  pitch;
  logic signed [brmm_pkg::IN_W-1:0]  pitch_rate;
  logic signed [brmm_pkg::IN_W-1:0]  yaw_rate;
  logic signed [brmm_pkg::IN_W-1:0]  left_wheel_speed;
  logic signed [brmm_pkg::IN_W-1:0]  right_wheel_speed;
  logic signed [brmm_pkg::IN_W-1:0]  speed_command;
  logic signed [brmm_pkg::IN_W-1:0]  turn_command;

  modport source (
    output valid, func, pitch, pitch_rate, yaw_rate, left_wheel_speed,
           right_wheel_speed, speed_command, turn_command,
    input  ready
  );
  modport sink (
    input  valid, func, pitch, pitch_rate, yaw_rate, left_wheel_speed,
           right_wheel_speed, speed_command, turn_command,
    output ready
  );
endinterface

// ===== rtl/core/brmm_out_if.sv =====
// ----------------------------------------------------------------------------
// brmm_out_if
// Motor drive word channel, valid/ready.
// ----------------------------------------------------------------------------
interface brmm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [brmm_pkg::OUT_W-1:0] left_drive;
  logic signed [brmm_pkg::OUT_W-1:0] right_drive;

  modport source (output valid, left_drive, right_drive, input ready);
  modport sink   (input valid, left_drive, right_drive, output ready);
endinterface

// ===== rtl/core/brmm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// brmm_cfg_if
// Register write channel, valid/ready, index and data.
// ----------------------------------------------------------------------------
interface brmm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [brmm_pkg::IDX_W-1:0]       index;
  logic [brmm_pkg::IN_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/balance_robot_motor_mixer.sv =====
// ----------------------------------------------------------------------------
// balance_robot_motor_mixer
// Cascaded balance/speed/steering controller for a two-wheeled robot.
// ----------------------------------------------------------------------------
// Use:
//   sensor : one word per control tick (pitch, rates, wheel speeds, commands).
//            func=0 runs the loops and yields one drive word; func=1 (robot
//            stopped) clears the speed filter and integral and yields nothing.
//   drive  : left/right drive, each saturated to +-OUT_LIMIT.
//   cfg    : gain and setpoint writes, always ready; write only while idle.
// Timing:
//   All nine products run through one digit-serial multiplier, 4 bits of the
//   narrow operand per cycle. A drive word is loaded into its output register
//   in the final state, and only then does the block return to idle and take
//   the next sensor word, so it never takes a word while a tick is computing.
//   A stop word is absorbed in its accept cycle.
// Reset: gains clear to zero, setpoint to 1.5 deg, filter and integral to 0.
// Stall: the drive word sits in its output register until taken; the next
//   tick computes meanwhile and waits in the final state if still blocked.
// ----------------------------------------------------------------------------
`include "balance_robot_motor_mixer_assert.svh"

module balance_robot_motor_mixer (
  input  logic        clk,
  input  logic        rst,
  brmm_in_if.sink     sensor,
  brmm_out_if.source  drive,
  brmm_cfg_if.sink    cfg
);

  // config registers
  logic signed [brmm_pkg::IN_W-1:0] angle_kp;
  logic signed [brmm_pkg::IN_W-1:0] angle_kd;
  logic signed [brmm_pkg::IN_W-1:0] speed_kp;
  logic signed [brmm_pkg::IN_W-1:0] speed_ki;
  logic signed [brmm_pkg::IN_W-1:0] turn_kp;
  logic signed [brmm_pkg::IN_W-1:0] turn_kd;
  logic signed [brmm_pkg::IN_W-1:0] pitch_setpoint;

  // loop state
  logic signed [brmm_pkg::FILT_W-1:0]  speed_filter;
  logic signed [brmm_pkg::INTEG_W-1:0] speed_integral;

  // latched tick operands
  logic signed [brmm_pkg::IN_W:0]   pitch_err;
  logic signed [brmm_pkg::IN_W:0]   neg_rate;
  logic signed [brmm_pkg::IN_W-1:0] mean;
  logic signed [brmm_pkg::IN_W-1:0] scmd;
  logic signed [brmm_pkg::IN_W-1:0] tcmd;
  logic signed [brmm_pkg::IN_W-1:0] yrate;

  // partial terms
  logic signed [brmm_pkg::FS_W-1:0]  filt_old;
  logic signed [brmm_pkg::MA_W-1:0]  ki_prod;
  logic signed [brmm_pkg::SUM_W-1:0] bal;
  logic signed [brmm_pkg::SUM_W-1:0] spd;
  logic signed [brmm_pkg::SUM_W-1:0] trn;

  brmm_pkg::state_t   state;
  brmm_pkg::state_t   state_next;
  logic               pending;
  brmm_pkg::mul_req_t mreq;
  brmm_pkg::mul_rsp_t mrsp;

  logic in_acc;
  logic is_mul;
  logic out_load;

  logic signed [brmm_pkg::IN_W:0]    wsum;
  logic signed [brmm_pkg::IN_W:0]    wsum_adj;
  logic signed [brmm_pkg::P_W-1:0]   p_sh8;
  logic signed [brmm_pkg::P_W-1:0]   p_sh16;
  logic signed [brmm_pkg::P_W-1:0]   p_sh32;
  logic signed [brmm_pkg::FS_W-1:0]  filt_sum;
  logic signed [brmm_pkg::FILT_W-1:0] filt_next;
  logic signed [brmm_pkg::INTEG_W-1:0] integ_sum;
  logic signed [brmm_pkg::INTEG_W-1:0] integ_next;
  logic signed [brmm_pkg::INTEG_W-1:0] scmd_q8;
  logic signed [brmm_pkg::SUM_W-1:0] lsum;
  logic signed [brmm_pkg::SUM_W-1:0] rsum;
  logic signed [brmm_pkg::SUM_W-1:0] lsat;
  logic signed [brmm_pkg::SUM_W-1:0] rsat;

  // assertion terms
  logic stop_acc;
  logic loop_clear;
  logic integ_ok;
  logic left_ok;
  logic right_ok;
  logic in_done;

  brmm_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  assign in_acc = sensor.valid && sensor.ready;

  // ---- datapath helpers ----
  always_comb begin
    // mean wheel speed, truncated toward zero
    wsum     = (brmm_pkg::IN_W+1)'(sensor.left_wheel_speed)
             + (brmm_pkg::IN_W+1)'(sensor.right_wheel_speed);
    wsum_adj = wsum + {{brmm_pkg::IN_W{1'b0}}, wsum[brmm_pkg::IN_W]};

    p_sh8  = mrsp.p >>> 8;
    p_sh16 = mrsp.p >>> 16;
    p_sh32 = mrsp.p >>> 32;

    // filter: asr(f*205 + m*51*256, 8) == asr(f*205, 8) + m*51
    filt_sum = filt_old + signed'(mrsp.p[brmm_pkg::FS_W-1:0]);
    if (filt_sum > brmm_pkg::FILT_MAX) begin
      filt_next = brmm_pkg::FILT_MAX[brmm_pkg::FILT_W-1:0];
    end else if (filt_sum < brmm_pkg::FILT_MIN) begin
      filt_next = brmm_pkg::FILT_MIN[brmm_pkg::FILT_W-1:0];
    end else begin
      filt_next = filt_sum[brmm_pkg::FILT_W-1:0];
    end

    scmd_q8   = signed'({{(brmm_pkg::INTEG_W-brmm_pkg::IN_W-8){scmd[brmm_pkg::IN_W-1]}},
                         scmd, 8'h00});
    integ_sum = speed_integral + brmm_pkg::INTEG_W'(speed_filter) - scmd_q8;
    if (integ_sum > brmm_pkg::INTEG_MAX) begin
      integ_next = brmm_pkg::INTEG_MAX;
    end else if (integ_sum < brmm_pkg::INTEG_MIN) begin
      integ_next = brmm_pkg::INTEG_MIN;
    end else begin
      integ_next = integ_sum;
    end

    // final mix and saturation
    lsum = bal + spd + trn;
    rsum = bal + spd - trn;
    if (lsum > brmm_pkg::DRV_MAX) begin
      lsat = brmm_pkg::DRV_MAX;
    end else if (lsum < brmm_pkg::DRV_MIN) begin
      lsat = brmm_pkg::DRV_MIN;
    end else begin
      lsat = lsum;
    end
    if (rsum > brmm_pkg::DRV_MAX) begin
      rsat = brmm_pkg::DRV_MAX;
    end else if (rsum < brmm_pkg::DRV_MIN) begin
      rsat = brmm_pkg::DRV_MIN;
    end else begin
      rsat = rsum;
    end
  end

  // ---- next state ----
  always_comb begin
    state_next = state;
    unique case (state)
      brmm_pkg::ST_IDLE: begin
        if (in_acc && !sensor.func) begin
          state_next = brmm_pkg::ST_BAL_P;
        end
      end
      brmm_pkg::ST_BAL_P:  if (mrsp.done) state_next = brmm_pkg::ST_BAL_D;
      brmm_pkg::ST_BAL_D:  if (mrsp.done) state_next = brmm_pkg::ST_FILT_A;
      brmm_pkg::ST_FILT_A: if (mrsp.done) state_next = brmm_pkg::ST_FILT_B;
      brmm_pkg::ST_FILT_B: if (mrsp.done) state_next = brmm_pkg::ST_INTEG;
      brmm_pkg::ST_INTEG:  state_next = brmm_pkg::ST_SPD_P;
      brmm_pkg::ST_SPD_P:  if (mrsp.done) state_next = brmm_pkg::ST_SPD_I1;
      brmm_pkg::ST_SPD_I1: if (mrsp.done) state_next = brmm_pkg::ST_SPD_I2;
      brmm_pkg::ST_SPD_I2: if (mrsp.done) state_next = brmm_pkg::ST_TRN_P;
      brmm_pkg::ST_TRN_P:  if (mrsp.done) state_next = brmm_pkg::ST_TRN_D;
      brmm_pkg::ST_TRN_D:  if (mrsp.done) state_next = brmm_pkg::ST_DONE;
      brmm_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = brmm_pkg::ST_IDLE;
        end
      end
      default: state_next = brmm_pkg::ST_IDLE;
    endcase
  end

  // ---- outputs: handshakes and multiplier operands ----
  always_comb begin
    sensor.ready = 1'b0;
    cfg.ready    = 1'b1;
    is_mul       = 1'b1;
    out_load     = 1'b0;
    mreq.a       = '0;
    mreq.b       = '0;
    unique case (state)
      brmm_pkg::ST_IDLE: begin
        sensor.ready = 1'b1;
        is_mul       = 1'b0;
      end
      brmm_pkg::ST_BAL_P: begin
        mreq.a = brmm_pkg::MA_W'(angle_kp);
        mreq.b = brmm_pkg::MB_W'(pitch_err);
      end
      brmm_pkg::ST_BAL_D: begin
        mreq.a = brmm_pkg::MA_W'(angle_kd);
        mreq.b = brmm_pkg::MB_W'(neg_rate);
      end
      brmm_pkg::ST_FILT_A: begin
        mreq.a = brmm_pkg::MA_W'(speed_filter);
        mreq.b = brmm_pkg::COEF_OLD;
      end
      brmm_pkg::ST_FILT_B: begin
        mreq.a = brmm_pkg::MA_W'(mean);
        mreq.b = brmm_pkg::COEF_NEW;
      end
      brmm_pkg::ST_INTEG: begin
        is_mul = 1'b0;
      end
      brmm_pkg::ST_SPD_P: begin
        mreq.a = brmm_pkg::MA_W'(speed_filter);
        mreq.b = brmm_pkg::MB_W'(speed_kp);
      end
      brmm_pkg::ST_SPD_I1: begin
        mreq.a = brmm_pkg::MA_W'(speed_integral);
        mreq.b = brmm_pkg::MB_W'(speed_ki);
      end
      brmm_pkg::ST_SPD_I2: begin
        mreq.a = ki_prod;
        mreq.b = brmm_pkg::COEF_TENTH;
      end
      brmm_pkg::ST_TRN_P: begin
        mreq.a = brmm_pkg::MA_W'(turn_kp);
        mreq.b = brmm_pkg::MB_W'(tcmd);
      end
      brmm_pkg::ST_TRN_D: begin
        mreq.a = brmm_pkg::MA_W'(turn_kd);
        mreq.b = brmm_pkg::MB_W'(yrate);
      end
      brmm_pkg::ST_DONE: begin
        is_mul   = 1'b0;
        out_load = !drive.valid || drive.ready;
      end
      default: begin
        is_mul = 1'b0;
      end
    endcase
    mreq.start = is_mul && !pending;
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= brmm_pkg::ST_IDLE;
      pending     <= 1'b0;
      drive.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (mreq.start) begin
        pending <= 1'b1;
      end else if (mrsp.done) begin
        pending <= 1'b0;
      end
      if (out_load) begin
        drive.valid <= 1'b1;
      end else if (drive.ready) begin
        drive.valid <= 1'b0;
      end
    end
  end

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_kp       <= '0;
      angle_kd       <= '0;
      speed_kp       <= '0;
      speed_ki       <= '0;
      turn_kp        <= '0;
      turn_kd        <= '0;
      pitch_setpoint <= brmm_pkg::PITCH_SP_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (brmm_pkg::cfg_reg_t'(cfg.index))
        brmm_pkg::REG_ANGLE_KP: angle_kp       <= cfg.data;
        brmm_pkg::REG_ANGLE_KD: angle_kd       <= cfg.data;
        brmm_pkg::REG_SPEED_KP: speed_kp       <= cfg.data;
        brmm_pkg::REG_SPEED_KI: speed_ki       <= cfg.data;
        brmm_pkg::REG_TURN_KP:  turn_kp        <= cfg.data;
        brmm_pkg::REG_TURN_KD:  turn_kd        <= cfg.data;
        brmm_pkg::REG_PITCH_SP: pitch_setpoint <= cfg.data;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // ---- loop state: filter and integral ----
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_filter   <= '0;
      speed_integral <= '0;
    end else if (in_acc && sensor.func) begin
      speed_filter   <= '0;
      speed_integral <= '0;
    end else if (state == brmm_pkg::ST_FILT_B && mrsp.done) begin
      speed_filter <= filt_next;
    end else if (state == brmm_pkg::ST_INTEG) begin
      speed_integral <= integ_next;
    end
  end

  // ---- tick operands and partial terms ----
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pitch_err <= (brmm_pkg::IN_W+1)'(pitch_setpoint) - (brmm_pkg::IN_W+1)'(sensor.pitch);
      neg_rate  <= -(brmm_pkg::IN_W+1)'(sensor.pitch_rate);
      mean      <= wsum_adj[brmm_pkg::IN_W:1];
      scmd      <= sensor.speed_command;
      tcmd      <= sensor.turn_command;
      yrate     <= sensor.yaw_rate;
    end
    if (mrsp.done) begin
      case (state)
        brmm_pkg::ST_BAL_P:  bal      <= p_sh16[brmm_pkg::SUM_W-1:0];
        brmm_pkg::ST_BAL_D:  bal      <= bal + p_sh8[brmm_pkg::SUM_W-1:0];
        brmm_pkg::ST_FILT_A: filt_old <= p_sh8[brmm_pkg::FS_W-1:0];
        brmm_pkg::ST_SPD_P:  spd      <= p_sh16[brmm_pkg::SUM_W-1:0];
        brmm_pkg::ST_SPD_I1: ki_prod  <= mrsp.p[brmm_pkg::MA_W-1:0];
        brmm_pkg::ST_SPD_I2: spd      <= spd - p_sh32[brmm_pkg::SUM_W-1:0];
        brmm_pkg::ST_TRN_P:  trn      <= p_sh8[brmm_pkg::SUM_W-1:0];
        brmm_pkg::ST_TRN_D:  trn      <= trn + p_sh8[brmm_pkg::SUM_W-1:0];
        default: ;
      endcase
    end
    if (out_load) begin
      drive.left_drive  <= lsat[brmm_pkg::OUT_W-1:0];
      drive.right_drive <= rsat[brmm_pkg::OUT_W-1:0];
    end
  end

  // ---- assertions ----
  assign stop_acc   = in_acc && sensor.func;
  assign loop_clear = (state == brmm_pkg::ST_IDLE) && (speed_filter == '0)
                   && (speed_integral == '0);
  assign integ_ok   = (speed_integral <= brmm_pkg::INTEG_MAX)
                   && (speed_integral >= brmm_pkg::INTEG_MIN);
  assign left_ok    = (drive.left_drive <= brmm_pkg::DRIVE_LIM)
                   && (drive.left_drive >= -brmm_pkg::DRIVE_LIM);
  assign right_ok   = (drive.right_drive <= brmm_pkg::DRIVE_LIM)
                   && (drive.right_drive >= -brmm_pkg::DRIVE_LIM);
  assign in_done    = (state == brmm_pkg::ST_DONE);

  `BRMM_ASSERT_NEXT(a_stop_clears, stop_acc, loop_clear, "stop word did not clear loop state")
  `BRMM_ASSERT_NOW(a_integ_bound, 1'b1, integ_ok, "speed integral out of clamp range")
  `BRMM_ASSERT_NOW(a_drive_sat, drive.valid, left_ok && right_ok, "drive word not saturated")
  `BRMM_ASSERT_NOW(a_word_from_done, $rose(drive.valid), $past(in_done), "word not from done")

endmodule

// ===== rtl/core/brmm_mul.sv =====
// ----------------------------------------------------------------------------
// brmm_mul
// Digit-serial signed multiplier, one 4-bit digit of b per cycle, MSB first.
// ----------------------------------------------------------------------------
module brmm_mul (
  input  logic               clk,
  input  logic               rst,
  input  brmm_pkg::mul_req_t req,
  output brmm_pkg::mul_rsp_t rsp
);

  logic signed [brmm_pkg::MA_W-1:0]       a_reg;
  logic        [brmm_pkg::MB_W-1:0]       b_reg;
  logic        [brmm_pkg::CNT_W-1:0]      cnt;
  logic                                   busy;
  logic                                   done;
  logic signed [brmm_pkg::P_W-1:0]        acc;

  logic        [brmm_pkg::DIG_W-1:0]      dig;
  logic signed [brmm_pkg::DIG_W:0]        sdig;
  logic signed [brmm_pkg::MA_W+brmm_pkg::DIG_W:0] part;
  logic signed [brmm_pkg::P_W-1:0]        acc_next;
  logic                                   last;

  always_comb begin
    dig = b_reg[brmm_pkg::MB_W-1 -: brmm_pkg::DIG_W];
    // top digit carries the sign, the rest are unsigned
    if (cnt == '0) begin
      sdig = {dig[brmm_pkg::DIG_W-1], dig};
    end else begin
      sdig = {1'b0, dig};
    end
    part     = a_reg * sdig;
    acc_next = (acc <<< brmm_pkg::DIG_W) + brmm_pkg::P_W'(part);
    last     = (cnt == brmm_pkg::CNT_W'(brmm_pkg::ND - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_reg <= req.a;
      b_reg <= req.b;
      acc   <= '0;
    end else if (busy) begin
      b_reg <= b_reg << brmm_pkg::DIG_W;
      acc   <= acc_next;
    end
  end

  assign rsp.done = done;
  assign rsp.p    = acc;

endmodule

// ===== dv/brmm_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// brmm_tb_pkg
// Sensor word function codes shared by the mixer testbench and its checker.
// ----------------------------------------------------------------------------
package brmm_tb_pkg;

  typedef enum logic {
    FUNC_TICK = 1'b0,   // run the loops, one drive word
    FUNC_STOP = 1'b1    // robot stopped: clear filter and integral, no drive word
  } tick_func_t;

endpackage

// ===== dv/brmm_checker.sv =====
// ----------------------------------------------------------------------------
// brmm_checker
// Watches the sensor, drive and cfg channels of the motor mixer, keeps its own
// copy of gains and loop state, predicts every drive word and compares.
// ----------------------------------------------------------------------------
module brmm_checker
  import brmm_pkg::*;
  import brmm_tb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  brmm_in_if   sensor,
  brmm_out_if  drive,
  brmm_cfg_if  cfg,
  output int   fails,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint WHEEL_AVG_HI = (longint'(1) <<< (FILT_W - 1)) - 1;
  localparam longint WHEEL_AVG_LO = -WHEEL_AVG_HI - 1;
  localparam longint INTEG_LIM    = longint'(20) * OUT_LIMIT * 256;

  typedef struct packed {
    logic signed [OUT_W-1:0] left;
    logic signed [OUT_W-1:0] right;
  } drive_word_t;

  // gains and setpoint as the block should hold them
  logic signed [IN_W-1:0] bal_kp, bal_kd, vel_kp, vel_ki, steer_kp, steer_kd;
  logic signed [IN_W-1:0] pitch_target;

  // loop state, Q8
  logic signed [FILT_W-1:0]  wheel_avg_q8;
  logic signed [INTEG_W-1:0] vel_integral_q8;

  drive_word_t pending_drives[$];
  int          errs;

  function automatic longint clip(input longint x, input longint lo, input longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // one control tick: updates the loop state, returns the drive word
  function automatic drive_word_t mix_drives(
    input logic signed [IN_W-1:0] pitch, pitch_rate, yaw_rate,
    input logic signed [IN_W-1:0] left_speed, right_speed, speed_cmd, turn_cmd
  );
    longint balance, velocity, steer, mean, avg, integ, left, right;
    drive_word_t d;
    balance = ((longint'(bal_kp) * (longint'(pitch_target) - longint'(pitch))) >>> 16)
            + ((longint'(bal_kd) * (0 - longint'(pitch_rate))) >>> 8);
    // truncating divide, not a shift
    mean  = (longint'(left_speed) + longint'(right_speed)) / 2;
    avg   = clip((longint'(wheel_avg_q8) * 205 + mean * 256 * 51) >>> 8,
                 WHEEL_AVG_LO, WHEEL_AVG_HI);
    integ = clip(longint'(vel_integral_q8) + avg - longint'(speed_cmd) * 256,
                 -INTEG_LIM, INTEG_LIM);
    wheel_avg_q8    = avg[FILT_W-1:0];
    vel_integral_q8 = integ[INTEG_W-1:0];
    velocity = ((longint'(vel_kp) * avg) >>> 16)
             - ((longint'(vel_ki) * integ * 6554) >>> 32);
    steer = ((longint'(steer_kp) * longint'(turn_cmd)) >>> 8)
          + ((longint'(steer_kd) * longint'(yaw_rate)) >>> 8);
    left  = clip(balance + velocity + steer, -OUT_LIMIT, OUT_LIMIT);
    right = clip(balance + velocity - steer, -OUT_LIMIT, OUT_LIMIT);
    d.left  = left[OUT_W-1:0];
    d.right = right[OUT_W-1:0];
    return d;
  endfunction

  initial errs = 0;

  always @(posedge clk) begin
    drive_word_t want;
    if (rst) begin
      bal_kp          = '0;
      bal_kd          = '0;
      vel_kp          = '0;
      vel_ki          = '0;
      steer_kp        = '0;
      steer_kd        = '0;
      pitch_target    = PITCH_SP_RST;
      wheel_avg_q8    = '0;
      vel_integral_q8 = '0;
      pending_drives.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          REG_ANGLE_KP: bal_kp       = cfg.data;
          REG_ANGLE_KD: bal_kd       = cfg.data;
          REG_SPEED_KP: vel_kp       = cfg.data;
          REG_SPEED_KI: vel_ki       = cfg.data;
          REG_TURN_KP:  steer_kp     = cfg.data;
          REG_TURN_KD:  steer_kd     = cfg.data;
          REG_PITCH_SP: pitch_target = cfg.data;
          default: ;  // unmapped index, dropped
        endcase
      end

      if (drive.valid && drive.ready) begin
        if (pending_drives.size() == 0) begin
          $error("drive word with no tick pending: left_drive %0d right_drive %0d",
                 drive.left_drive, drive.right_drive);
          errs++;
        end else begin
          want = pending_drives.pop_front();
          if (drive.left_drive !== want.left) begin
            $error("left_drive: expected %0d, got %0d", want.left, drive.left_drive);
            errs++;
          end
          if (drive.right_drive !== want.right) begin
            $error("right_drive: expected %0d, got %0d", want.right, drive.right_drive);
            errs++;
          end
        end
      end

      if (sensor.valid && sensor.ready) begin
        if (sensor.func == FUNC_STOP) begin
          wheel_avg_q8    = '0;
          vel_integral_q8 = '0;
        end else begin
          pending_drives.push_back(mix_drives(sensor.pitch, sensor.pitch_rate,
                                              sensor.yaw_rate, sensor.left_wheel_speed,
                                              sensor.right_wheel_speed,
                                              sensor.speed_command, sensor.turn_command));
        end
      end
    end
    fails   <= errs;
    pending <= pending_drives.size();
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Top of the motor mixer bench: drives sensor and cfg words, pulls drive
// words with random back-pressure, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import brmm_pkg::*;
  import brmm_tb_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;  // unmapped index
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 400;       // long drive-side hold-off
  localparam int RANDOM_ITEMS  = 1730;
  localparam int NUM_PHASES    = 7;
  localparam longint CYCLE_LIMIT = 1_200_000;

  typedef enum {GAINS_SMALL, GAINS_FULL, GAINS_MAX, GAINS_MIN, GAINS_ZERO} gain_mode_t;

  localparam gain_mode_t PHASE_MODES [NUM_PHASES] =
    '{GAINS_SMALL, GAINS_FULL, GAINS_MAX, GAINS_SMALL, GAINS_MIN, GAINS_FULL, GAINS_ZERO};

  typedef struct packed {
    tick_func_t             func;
    logic signed [IN_W-1:0] pitch;
    logic signed [IN_W-1:0] pitch_rate;
    logic signed [IN_W-1:0] yaw_rate;
    logic signed [IN_W-1:0] left_speed;
    logic signed [IN_W-1:0] right_speed;
    logic signed [IN_W-1:0] speed_cmd;
    logic signed [IN_W-1:0] turn_cmd;
  } sensor_word_t;

  logic   clk = 1'b0;
  logic   rst;
  int     fail_cnt;
  int     pending_cnt;
  int     items_sent = 0;
  bit     hold_req = 1'b0;    // main flow asks the drive side for a long hold-off
  bit     rx_calm  = 1'b0;    // drive side never stalls while set
  longint cycle_cnt = 0;

  brmm_in_if  sens_if ();
  brmm_out_if drv_if ();
  brmm_cfg_if cfg_if ();

  balance_robot_motor_mixer u_top (
    .clk    (clk),
    .rst    (rst),
    .sensor (sens_if),
    .drive  (drv_if),
    .cfg    (cfg_if)
  );

  brmm_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .sensor  (sens_if),
    .drive   (drv_if),
    .cfg     (cfg_if),
    .fails   (fail_cnt),
    .pending (pending_cnt)
  );

  always #1 clk = ~clk;

  // Idle run length: mostly none, often a few cycles, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(15, 80);
  endfunction

  // Field value: extremes, zero, small values and full-range noise.
  function automatic logic signed [IN_W-1:0] rand_field();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      3, 4, 5: return IN_W'(int'($urandom_range(0, 600)) - 300);
      default: return IN_W'($urandom());
    endcase
  endfunction

  function automatic sensor_word_t rand_word(input tick_func_t fn);
    sensor_word_t w;
    w.func        = fn;
    w.pitch       = rand_field();
    w.pitch_rate  = rand_field();
    w.yaw_rate    = rand_field();
    w.left_speed  = rand_field();
    w.right_speed = rand_field();
    w.speed_cmd   = rand_field();
    w.turn_cmd    = rand_field();
    return w;
  endfunction

  // Small step from the previous tick, so the filter and integral evolve
  // the way they would on a moving robot rather than being hammered.
  function automatic sensor_word_t nudge(input sensor_word_t w);
    w.pitch       += IN_W'(int'($urandom_range(0, 64)) - 32);
    w.pitch_rate  += IN_W'(int'($urandom_range(0, 64)) - 32);
    w.yaw_rate    += IN_W'(int'($urandom_range(0, 64)) - 32);
    w.left_speed  += IN_W'(int'($urandom_range(0, 64)) - 32);
    w.right_speed += IN_W'(int'($urandom_range(0, 64)) - 32);
    w.speed_cmd   += IN_W'(int'($urandom_range(0, 16)) - 8);
    w.turn_cmd    += IN_W'(int'($urandom_range(0, 16)) - 8);
    return w;
  endfunction

  function automatic logic [IN_W-1:0] pick_gain(input gain_mode_t mode);
    case (mode)
      GAINS_ZERO:  return '0;
      GAINS_MAX:   return 16'h7fff;
      GAINS_MIN:   return 16'h8000;
      GAINS_SMALL: return IN_W'(int'($urandom_range(0, 1024)) - 512);
      default:     return IN_W'($urandom());
    endcase
  endfunction

  // Offer one sensor word. An optional idle gap goes first; valid stays up
  // after the handshake so back-to-back words never drop it for a step.
  task automatic send_word(input sensor_word_t w, input bit eager);
    int unsigned gap;
    gap = eager ? 0 : idle_len();
    if (gap != 0) begin
      sens_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sens_if.valid             <= 1'b1;
    sens_if.func              <= w.func;
    sens_if.pitch             <= w.pitch;
    sens_if.pitch_rate        <= w.pitch_rate;
    sens_if.yaw_rate          <= w.yaw_rate;
    sens_if.left_wheel_speed  <= w.left_speed;
    sens_if.right_wheel_speed <= w.right_speed;
    sens_if.speed_command     <= w.speed_cmd;
    sens_if.turn_command      <= w.turn_cmd;
    do @(posedge clk); while (!sens_if.ready);
    items_sent++;
  endtask

  // Stop offering, wait for every predicted drive word, then let the block
  // settle so a stop word still in flight cannot overlap a cfg write.
  task automatic drain();
    sens_if.valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [IN_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  // Full register set; the unmapped index gets junk that must be dropped.
  task automatic load_gains(input logic [IN_W-1:0] akp, akd, skp, ski, tkp, tkd, sp);
    cfg_write(REG_SPARE, IN_W'($urandom()));
    cfg_write(REG_ANGLE_KP, akp);
    cfg_write(REG_ANGLE_KD, akd);
    cfg_write(REG_SPEED_KP, skp);
    cfg_write(REG_SPEED_KI, ski);
    cfg_write(REG_TURN_KP, tkp);
    cfg_write(REG_TURN_KD, tkd);
    cfg_write(REG_PITCH_SP, sp);
    cfg_if.valid <= 1'b0;
  endtask

  // A run: maybe a stop word first (state cleared), then a stretch of ticks
  // that mostly drift and sometimes jump to fresh random values.
  task automatic run_episode(input bit eager);
    sensor_word_t w;
    int unsigned  len;
    len = $urandom_range(4, 40);
    if ($urandom_range(0, 3) == 0) send_word(rand_word(FUNC_STOP), eager);
    w = rand_word(FUNC_TICK);
    repeat (len) begin
      if ($urandom_range(0, 9) < 7) w = nudge(w);
      else                          w = rand_word(FUNC_TICK);
      send_word(w, eager);
    end
  endtask

  // Drive side: random stalls, long hold-off on request, none while calm.
  initial begin
    int unsigned gap;
    drv_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = rx_calm ? 0 : idle_len();
      end
      if (gap != 0) begin
        drv_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      drv_if.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // Watchdog.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $error("timeout after %0d cycles, %0d drive words outstanding", cycle_cnt, pending_cnt);
    $display("FAIL balance_robot_motor_mixer");
    $finish;
  end

  // Main flow: reset, directed words, then random phases under various gains.
  initial begin
    int phase_end;
    rst                       <= 1'b1;
    sens_if.valid             <= 1'b0;
    sens_if.func              <= FUNC_TICK;
    sens_if.pitch             <= '0;
    sens_if.pitch_rate        <= '0;
    sens_if.yaw_rate          <= '0;
    sens_if.left_wheel_speed  <= '0;
    sens_if.right_wheel_speed <= '0;
    sens_if.speed_command     <= '0;
    sens_if.turn_command      <= '0;
    cfg_if.valid              <= 1'b0;
    cfg_if.index              <= '0;
    cfg_if.data               <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset gains are all zero: expect a zero drive word
    send_word(sensor_word_t'{FUNC_TICK, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff,
                             16'sh7fff, 16'sh8000, 16'sh7fff}, 1'b0);
    drain();
    load_gains(16'sd256, 16'sd128, 16'sd512, 16'sd2560, 16'sd256, -16'sd256, 16'sd384);

    // field extremes
    send_word(sensor_word_t'{FUNC_TICK, '0, '0, '0, '0, '0, '0, '0}, 1'b0);
    send_word(sensor_word_t'{FUNC_TICK, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                             16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b0);
    send_word(sensor_word_t'{FUNC_TICK, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                             16'sh8000, 16'sh8000, 16'sh8000}, 1'b0);
    send_word(sensor_word_t'{FUNC_TICK, 16'sh8000, '0, '0, '0, '0, '0, '0}, 1'b0);
    // stop clears state, payload ignored; next tick starts from zero
    send_word(sensor_word_t'{FUNC_STOP, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                             16'sh7fff, 16'sh8000, 16'sh7fff}, 1'b0);
    send_word(sensor_word_t'{FUNC_TICK, '0, '0, '0, 16'sd100, 16'sd101, '0, '0}, 1'b0);
    // drive the integral into its positive clamp, then odd wheel sum at the top
    repeat (5) send_word(sensor_word_t'{FUNC_TICK, '0, '0, '0, 16'sh7fff, 16'sh7fff,
                                        16'sh8000, '0}, 1'b0);
    send_word(sensor_word_t'{FUNC_TICK, '0, '0, '0, 16'sh7fff, 16'sh7ffe,
                             16'sh8000, '0}, 1'b0);
    send_word(sensor_word_t'{FUNC_STOP, '0, '0, '0, '0, '0, '0, '0}, 1'b0);
    // and into the negative clamp, with a negative odd wheel sum
    repeat (4) send_word(sensor_word_t'{FUNC_TICK, '0, '0, '0, 16'sh8000, 16'sh8000,
                                        16'sh7fff, '0}, 1'b0);
    send_word(sensor_word_t'{FUNC_TICK, '0, '0, '0, -16'sd3, '0, 16'sh7fff, '0}, 1'b0);
    // steering saturates the two wheels in opposite directions
    send_word(sensor_word_t'{FUNC_TICK, 16'sd384, '0, '0, '0, '0, '0, 16'sh7fff}, 1'b0);
    send_word(sensor_word_t'{FUNC_TICK, 16'sd384, '0, 16'sh7fff, '0, '0, '0, 16'sh8000}, 1'b0);
    // back-to-back stops
    send_word(sensor_word_t'{FUNC_STOP, '0, '0, '0, '0, '0, '0, '0}, 1'b1);
    send_word(sensor_word_t'{FUNC_STOP, '0, '0, '0, '0, '0, '0, '0}, 1'b1);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // gains only change with the block idle
      drain();
      load_gains(pick_gain(PHASE_MODES[ph]), pick_gain(PHASE_MODES[ph]),
                 pick_gain(PHASE_MODES[ph]), pick_gain(PHASE_MODES[ph]),
                 pick_gain(PHASE_MODES[ph]), pick_gain(PHASE_MODES[ph]),
                 pick_gain(PHASE_MODES[ph]));
      phase_end = items_sent + RANDOM_ITEMS / NUM_PHASES;
      if (ph == 3) begin
        // drive side holds off while ticks keep coming: the output register
        // fills, the next tick parks in its final state and sensor stalls
        hold_req = 1'b1;
        repeat (12) send_word(rand_word(FUNC_TICK), 1'b1);
      end
      rx_calm = (ph == 5);
      while (items_sent < phase_end) begin
        run_episode(rx_calm);
        // now and then wait for every drive word before going on
        if ($urandom_range(0, 19) == 0) drain();
      end
      rx_calm = 1'b0;
    end

    drain();
    if (fail_cnt == 0) begin
      $display("PASS balance_robot_motor_mixer");
    end else begin
      $display("FAIL balance_robot_motor_mixer");
    end
    $finish;
  end

endmodule
